### rtl/gfp_pkg.sv
// Shared types and constants for the grid falling-path maximum-sum unit.
// No dependencies; every other file in rtl/ imports this package.
package gfp_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CELL_W = 16;
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned GRID_W = 7;

  // Defaults for the top-level parameters and the size register.
  localparam int unsigned DEFAULT_MAX_SIZE = 64;
  localparam logic [GRID_W-1:0] GRID_RESET = 7'd8;

  // Saturation limits and the "nothing found" marker for a path sum.
  localparam logic signed [SUM_W-1:0] SUM_MAX  = 22'sh1FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN  = -22'sh200000;
  localparam logic signed [SUM_W-1:0] SUM_NONE = -22'sd1;

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [COL_W-1:0]  column_t;

  // Position flags of one cell, handed from the input stage to the adder.
  typedef struct packed {
    logic first_row;
    logic has_left;
    logic has_right;
  } step_ctrl_t;

endpackage

### rtl/gfp_row_mem.sv
// Row store of best path sums: one write and one registered read per cycle.
// A read of the entry being written in the same cycle returns the new data.
// Depends on gfp_pkg.
module gfp_row_mem #(
  parameter int unsigned DEPTH = gfp_pkg::DEFAULT_MAX_SIZE,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  gfp_pkg::sum_t       wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output gfp_pkg::sum_t       rd_data_o
);
  import gfp_pkg::*;

  sum_t       mem [DEPTH];
  sum_t       rd_data_q;
  sum_t       fwd_data_q;
  logic       fwd_q;
  logic       hit;

  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  // Storage array and its registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (rd_en_i && hit) begin
      fwd_data_q <= wr_data_i;
    end
  end

  // Remember whether the last read collided with a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= hit;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

### rtl/gfp_cell_step.sv
// Path-sum step for one cell: three-way max over the row above, add, saturate.
// Depends on gfp_pkg.
module gfp_cell_step (
  input  gfp_pkg::cell_t     cell_i,
  input  gfp_pkg::sum_t      left_i,
  input  gfp_pkg::sum_t      center_i,
  input  gfp_pkg::sum_t      right_i,
  input  gfp_pkg::step_ctrl_t ctrl_i,
  output gfp_pkg::sum_t      sum_o
);
  import gfp_pkg::*;

  sum_t              best;
  sum_t              cell_ext;
  logic [SUM_W:0]    wide;

  assign cell_ext = {{(SUM_W-CELL_W){cell_i[CELL_W-1]}}, cell_i};

  // Pick the largest neighbor that lies inside the grid.
  always_comb begin
    best = center_i;
    if (ctrl_i.has_left && (left_i > best)) begin
      best = left_i;
    end
    if (ctrl_i.has_right && (right_i > best)) begin
      best = right_i;
    end
  end

  // One extra bit catches overflow; saturate to the sum range.
  assign wide = {best[SUM_W-1], best} + {cell_ext[SUM_W-1], cell_ext};

  always_comb begin
    if (ctrl_i.first_row) begin
      sum_o = cell_ext;
    end else if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum_o = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_o = wide[SUM_W-1:0];
    end
  end

endmodule

### rtl/grid_falling_path_max_sum_unit.sv
// Grid falling-path maximum sum: takes an N by N grid of signed cells in
// row-major order, one beat per clock, and after the last cell returns the
// largest path sum of the bottom row with its 1-based column (-1 and 0 when
// no sum is above -1). The unit sustains one cell per clock with no gaps
// unless a finished grid is held by out_stall_i: an input register feeds the
// max/add/saturate step, which writes the row store and the result register.
// The row store is read one column ahead on its single read port, which is
// what holds the step to one cell per clock. Writing grid_size restarts the
// grid and must only happen while the unit is idle.
// Depends on gfp_pkg, gfp_row_mem and gfp_cell_step.
module grid_falling_path_max_sum_unit #(
  parameter int unsigned MAX_SIZE = gfp_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       grid_size_we_i,
  input  logic [gfp_pkg::GRID_W-1:0] grid_size_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  gfp_pkg::cell_t             cell_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output gfp_pkg::sum_t              best_sum_o,
  output gfp_pkg::column_t           best_column_o
);
  import gfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIZE);
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);

  // Effective grid size: zero works as one, large values clamp to MAX_SIZE.
  function automatic logic [NW-1:0] clamp_size(input logic [GRID_W-1:0] g);
    logic [NW-1:0] n;
    if (g == '0) begin
      n = NW'(1);
    end else if (32'(g) > MAX_SIZE) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(g);
    end
    return n;
  endfunction

  logic [NW-1:0]  n_q;
  logic [CW-1:0]  col_cnt_q, col_cnt_d;
  logic [CW-1:0]  row_cnt_q, row_cnt_d;
  logic           acc_last_col, acc_last_row;
  logic           accept;

  // Input register of the current cell.
  logic           valid_q;
  cell_t          cell_q;
  logic [CW-1:0]  col_q;
  logic           last_col_q, last_row_q;
  step_ctrl_t     ctrl_q;

  logic           is_end;
  logic           fire;
  sum_t           right;
  sum_t           sum;
  sum_t           left_q, center_q;
  sum_t           run_best_q, run_best_d;
  column_t        run_col_q, run_col_d;
  logic           take_best;

  logic           out_valid_q;
  sum_t           out_sum_q;
  column_t        out_col_q;

  // Handshake: the input register drains unless a finished grid is blocked.
  assign is_end     = last_col_q && last_row_q;
  assign fire       = valid_q && !(is_end && out_valid_q && out_stall_i);
  assign in_stall_o = valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Position of the arriving cell.
  assign acc_last_col = (NW'(col_cnt_q) == (n_q - NW'(1)));
  assign acc_last_row = (NW'(row_cnt_q) == (n_q - NW'(1)));
  assign col_cnt_d    = acc_last_col ? '0 : col_cnt_q + CW'(1);
  assign row_cnt_d    = !acc_last_col ? row_cnt_q :
                        (acc_last_row ? '0 : row_cnt_q + CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= clamp_size(GRID_RESET);
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (grid_size_we_i) begin
      n_q       <= clamp_size(grid_size_i);
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Input register: control part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (fire) begin
      valid_q <= 1'b0;
    end
  end

  // Input register: payload part.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q           <= cell_value_i;
      col_q            <= col_cnt_q;
      last_col_q       <= acc_last_col;
      last_row_q       <= acc_last_row;
      ctrl_q.first_row <= (row_cnt_q == '0);
      ctrl_q.has_left  <= (col_cnt_q != '0);
      ctrl_q.has_right <= !acc_last_col;
    end
  end

  // Row store, read one column ahead (wrapping to column zero).
  gfp_row_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (CW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fire),
    .wr_addr_i (col_q),
    .wr_data_i (sum),
    .rd_en_i   (accept),
    .rd_addr_i (col_cnt_d),
    .rd_data_o (right)
  );

  gfp_cell_step u_cell_step (
    .cell_i   (cell_q),
    .left_i   (left_q),
    .center_i (center_q),
    .right_i  (right),
    .ctrl_i   (ctrl_q),
    .sum_o    (sum)
  );

  // Slide the window of the row above; a one-column grid reuses its own sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      center_q <= '0;
    end else if (fire) begin
      left_q   <= center_q;
      center_q <= (n_q == NW'(1)) ? sum : right;
    end
  end

  // Running maximum of the bottom row; first column wins on ties.
  assign take_best  = last_row_q && (sum > run_best_q);
  assign run_best_d = take_best ? sum : run_best_q;
  assign run_col_d  = take_best ? COL_W'(32'(col_q) + 32'd1) : run_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_best_q <= SUM_NONE;
      run_col_q  <= '0;
    end else if (grid_size_we_i || (fire && is_end)) begin
      run_best_q <= SUM_NONE;
      run_col_q  <= '0;
    end else if (fire) begin
      run_best_q <= run_best_d;
      run_col_q  <= run_col_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_end) begin
      out_sum_q <= run_best_d;
      out_col_q <= run_col_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_sum_o    = out_sum_q;
  assign best_column_o = out_col_q;

`ifndef ASSERT_OFF
  // A new result beat only follows the last cell of a grid.
  a_result_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && is_end))
    else $error("result appeared without a finished grid");

  // The column counter never leaves the grid.
  a_col_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(col_cnt_q) < n_q)
    else $error("column counter beyond grid size");

  // The running best carries a column exactly when it is above -1.
  a_best_column_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_col_q == '0) == (run_best_q == SUM_NONE))
    else $error("running best and its column disagree");
`endif

endmodule
